>>> rtl/fisd_pkg.sv
// Package for the flux interval stream decoder: widths, byte codes, parse phases
// and the result record shared by the parser, result queue and top level.
// No dependencies.
package fisd_pkg;

    localparam int COUNT_BITS_DEFAULT = 20;
    localparam int MAX_WIDTH          = 20;
    localparam int TICK_WIDTH         = 27;
    localparam int OUT_COUNT_WIDTH    = 20;
    localparam int PREFIX_WIDTH       = 3;
    localparam int LOW_FIELDS_WIDTH   = 20;

    localparam logic [MAX_WIDTH-1:0] MAX_INTERVALS_RESET = 20'hFFFFF;

    // Lead byte codes
    localparam logic [7:0] BYTE_STREAM_END = 8'd0;
    localparam logic [7:0] BYTE_DIRECT_MAX = 8'd249;
    localparam logic [7:0] BYTE_PAIR_MIN   = 8'd250;
    localparam logic [7:0] BYTE_PAIR_MAX   = 8'd254;
    localparam logic [7:0] OPCODE_SPACE    = 8'd2;

    localparam logic [TICK_WIDTH-1:0] PAIR_BASE = 27'd249;

    localparam int FIFO_DEPTH = 4;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_PAIR   = 7'b0000010,
        PH_OPCODE = 7'b0000100,
        PH_SPACE0 = 7'b0001000,
        PH_SPACE1 = 7'b0010000,
        PH_SPACE2 = 7'b0100000,
        PH_SPACE3 = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [TICK_WIDTH-1:0]      interval_ticks;
        logic                       stream_end;
        logic [OUT_COUNT_WIDTH-1:0] interval_count;
    } result_t;

    // Results produced by one byte, in order: res0 first, res1 second
    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

>>> rtl/fisd_stream_if.sv
// Valid/ready channel interfaces for the flux interval stream decoder:
// raw byte input channel and decoded result output channel.
// No dependencies.
interface fisd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fisd_out_if;
    logic        valid;
    logic        ready;
    logic [26:0] interval_ticks;
    logic        stream_end;
    logic [19:0] interval_count;

    modport source (output valid, output interval_ticks, output stream_end,
                    output interval_count, input ready);
    modport sink (input valid, input interval_ticks, input stream_end,
                  input interval_count, output ready);
endinterface

>>> rtl/flux_interval_stream_decoder.sv
// Flux interval stream decoder: one raw flux byte per input transaction, one
// decoded interval or end-of-stream record per output transaction.
// Top level; uses fisd_pkg, fisd_stream_if, fisd_parser and fisd_result_fifo.
//
// A byte is decoded in the cycle it is accepted and its results are visible on
// the output channel from the next cycle. The block takes one byte per cycle;
// the rate is set by the four-entry result queue, which accepts a byte only
// while two entries are free. Most bytes give zero or one result, so with a
// consumer that takes one result per cycle the queue drains as fast as it
// fills. A byte that yields an interval and an end record together leaves one
// extra entry behind; once three entries are waiting the input stalls while an
// entry drains, so a run of such bytes is taken at a lower rate. Bytes that
// give no result let the queue catch up. max_intervals is written through
// cfg_wr_en/cfg_wr_data and should only change while no bytes are in flight.
module flux_interval_stream_decoder #(
    parameter int COUNT_BITS = fisd_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    fisd_in_if.sink                        in_stream,
    fisd_out_if.source                     out_stream,
    input  logic                           cfg_wr_en,
    input  logic [fisd_pkg::MAX_WIDTH-1:0] cfg_wr_data
);

    fisd_pkg::push_t push;
    logic            room;
    logic            in_fire;

    assign in_stream.ready = room;
    assign in_fire         = in_stream.valid && room;

    fisd_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .data_byte   (in_stream.data_byte),
        .last_byte   (in_stream.last_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push)
    );

    fisd_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .out_stream (out_stream)
    );

endmodule

>>> rtl/fisd_parser.sv
// Byte parser of the flux interval stream decoder: parse state, interval counter,
// limit register and the decode of one byte into up to two results. Uses fisd_pkg.
module fisd_parser #(
    parameter int COUNT_BITS = fisd_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_fire,
    input  logic [7:0]                     data_byte,
    input  logic                           last_byte,
    input  logic                           cfg_wr_en,
    input  logic [fisd_pkg::MAX_WIDTH-1:0] cfg_wr_data,
    output fisd_pkg::push_t                push
);

    localparam int CMP_WIDTH = (COUNT_BITS > fisd_pkg::MAX_WIDTH) ? COUNT_BITS
                                                                  : fisd_pkg::MAX_WIDTH;
    localparam logic [COUNT_BITS-1:0] COUNT_CAP = {COUNT_BITS{1'b1}};

    fisd_pkg::phase_t                           phase_reg, phase_next;
    logic [fisd_pkg::PREFIX_WIDTH-1:0]          pair_reg, pair_next;
    logic [fisd_pkg::LOW_FIELDS_WIDTH-1:0]      acc_reg, acc_next;
    logic [COUNT_BITS-1:0]                      cnt_reg, cnt_next;
    logic                                       fin_reg, fin_next;
    logic [fisd_pkg::MAX_WIDTH-1:0]             max_reg;

    logic [COUNT_BITS-1:0]                      cnt_inc;
    logic [COUNT_BITS-1:0]                      cnt_out;
    logic [CMP_WIDTH-1:0]                       max_wide;
    logic                                       limit_now;
    logic                                       limit_inc;
    logic [6:0]                                 field;
    logic [7:0]                                 prefix_full;
    logic [fisd_pkg::TICK_WIDTH-1:0]            pair_ticks;
    logic [fisd_pkg::TICK_WIDTH-1:0]            ticks;
    logic                                       emit;
    logic                                       end_dec;
    logic                                       end_any;
    logic [fisd_pkg::OUT_COUNT_WIDTH-1:0]       count_field;
    fisd_pkg::result_t                          iv_res;
    fisd_pkg::result_t                          end_res;

    assign cnt_inc   = cnt_reg + 1'b1;
    assign max_wide  = CMP_WIDTH'(max_reg);
    assign limit_now = (CMP_WIDTH'(cnt_reg) >= max_wide) || (cnt_reg == COUNT_CAP);
    assign limit_inc = (CMP_WIDTH'(cnt_inc) >= max_wide) || (cnt_inc == COUNT_CAP);
    assign field     = data_byte[7:1];
    assign prefix_full = data_byte - fisd_pkg::BYTE_PAIR_MIN;

    // 249 + prefix * 255 + second byte
    assign pair_ticks = fisd_pkg::PAIR_BASE
                      + fisd_pkg::TICK_WIDTH'(data_byte)
                      + (fisd_pkg::TICK_WIDTH'(pair_reg) << 8)
                      - fisd_pkg::TICK_WIDTH'(pair_reg);

    always_comb
    begin
        phase_next = phase_reg;
        pair_next  = pair_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        fin_next   = fin_reg;
        emit       = 1'b0;
        end_dec    = 1'b0;
        ticks      = '0;

        if (in_fire && !fin_reg)
        begin
            case (phase_reg)
                fisd_pkg::PH_IDLE:
                begin
                    if (limit_now || data_byte == fisd_pkg::BYTE_STREAM_END)
                    begin
                        end_dec = 1'b1;
                    end
                    else if (data_byte <= fisd_pkg::BYTE_DIRECT_MAX)
                    begin
                        emit  = 1'b1;
                        ticks = fisd_pkg::TICK_WIDTH'(data_byte);
                    end
                    else if (data_byte <= fisd_pkg::BYTE_PAIR_MAX)
                    begin
                        pair_next  = prefix_full[fisd_pkg::PREFIX_WIDTH-1:0];
                        phase_next = fisd_pkg::PH_PAIR;
                    end
                    else
                    begin
                        phase_next = fisd_pkg::PH_OPCODE;
                    end
                end
                fisd_pkg::PH_PAIR:
                begin
                    emit  = 1'b1;
                    ticks = pair_ticks;
                end
                fisd_pkg::PH_OPCODE:
                begin
                    // skip every opcode but the long space
                    phase_next = (data_byte == fisd_pkg::OPCODE_SPACE) ? fisd_pkg::PH_SPACE0
                                                                      : fisd_pkg::PH_IDLE;
                end
                fisd_pkg::PH_SPACE0:
                begin
                    acc_next   = fisd_pkg::LOW_FIELDS_WIDTH'(field[5:0]);
                    phase_next = fisd_pkg::PH_SPACE1;
                end
                fisd_pkg::PH_SPACE1:
                begin
                    acc_next[12:6] = field;
                    phase_next     = fisd_pkg::PH_SPACE2;
                end
                fisd_pkg::PH_SPACE2:
                begin
                    acc_next[19:13] = field;
                    phase_next      = fisd_pkg::PH_SPACE3;
                end
                fisd_pkg::PH_SPACE3:
                begin
                    emit  = 1'b1;
                    ticks = {field, acc_reg};
                end
                default:
                begin
                    phase_next = fisd_pkg::PH_IDLE;
                end
            endcase

            if (emit)
            begin
                cnt_next   = cnt_inc;
                phase_next = fisd_pkg::PH_IDLE;
                end_dec    = limit_inc;
            end
            if (end_dec)
            begin
                fin_next   = 1'b1;
                phase_next = fisd_pkg::PH_IDLE;
            end
        end

        end_any = end_dec || (in_fire && last_byte && !fin_reg);

        // end of buffer: drop any partial sequence and start a new stream
        if (in_fire && last_byte)
        begin
            phase_next = fisd_pkg::PH_IDLE;
            pair_next  = '0;
            acc_next   = '0;
            cnt_next   = '0;
            fin_next   = 1'b0;
        end
    end

    assign cnt_out     = emit ? cnt_inc : cnt_reg;
    assign count_field = fisd_pkg::OUT_COUNT_WIDTH'(CMP_WIDTH'(cnt_out));

    assign iv_res.interval_ticks  = ticks;
    assign iv_res.stream_end      = 1'b0;
    assign iv_res.interval_count  = count_field;
    assign end_res.interval_ticks = '0;
    assign end_res.stream_end     = 1'b1;
    assign end_res.interval_count = count_field;

    assign push.push0 = emit || end_any;
    assign push.push1 = emit && end_any;
    assign push.res0  = emit ? iv_res : end_res;
    assign push.res1  = end_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fisd_pkg::PH_IDLE;
            pair_reg  <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            fin_reg   <= 1'b0;
            max_reg   <= fisd_pkg::MAX_INTERVALS_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            pair_reg  <= pair_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            fin_reg   <= fin_next;
            if (cfg_wr_en)
            begin
                max_reg <= cfg_wr_data;
            end
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> phase_reg == fisd_pkg::PH_IDLE)
        else $error("finished stream left parser outside idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_byte |=> cnt_reg == '0 && !fin_reg)
        else $error("last byte did not restart the stream");

    assert property (@(posedge clk) disable iff (!rst_n)
        push.push1 |-> push.push0 && push.res1.stream_end && !push.res0.stream_end)
        else $error("second result is not an end following an interval");
`endif

endmodule

>>> rtl/fisd_result_fifo.sv
// Result queue of the flux interval stream decoder: takes up to two results a
// cycle from the parser and hands them out one transaction at a time. Uses fisd_pkg.
module fisd_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  fisd_pkg::push_t   push,
    output logic              room,
    fisd_out_if.source        out_stream
);

    localparam int PTR_BITS = $clog2(fisd_pkg::FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(fisd_pkg::FIFO_DEPTH + 1);

    fisd_pkg::result_t     mem_reg [fisd_pkg::FIFO_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [PTR_BITS-1:0]   wr_ptr_p1;
    logic                  pop;
    fisd_pkg::result_t     head;

    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;
    assign pop       = out_stream.valid && out_stream.ready;

    // accept a byte only while two entries are free
    assign room = (count_reg <= CNT_BITS'(fisd_pkg::FIFO_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.push0) + PTR_BITS'(push.push1);
    assign rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
    assign count_next  = count_reg + CNT_BITS'(push.push0) + CNT_BITS'(push.push1)
                       - CNT_BITS'(pop);

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.push1)
        begin
            mem_reg[wr_ptr_p1] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head = mem_reg[rd_ptr_reg];

    assign out_stream.valid          = (count_reg != '0);
    assign out_stream.interval_ticks = head.interval_ticks;
    assign out_stream.stream_end     = head.stream_end;
    assign out_stream.interval_count = head.interval_count;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(fisd_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push.push0 || push.push1) && !pop |=> count_reg > $past(count_reg))
        else $error("pushed result lost in queue");
`endif

endmodule

>>> tb/sv/tb_flux_interval_stream_decoder.sv
`timescale 1ns / 1ps
// Testbench for flux_interval_stream_decoder: directed and random byte streams,
// a transaction-level predictor of the decoded intervals, and random stalls on both channels.
// Depends on fisd_pkg, fisd_stream_if and the decoder RTL.
module tb_flux_interval_stream_decoder;

    localparam int          ITEM_TARGET  = 1250;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          LONG_HOLD    = 300;
    localparam int unsigned COUNT_CAP    = (1 << fisd_pkg::COUNT_BITS_DEFAULT) - 1;
    localparam logic [7:0]  BYTE_OPCODE  = 8'd255;
    localparam logic [7:0]  OPCODE_INDEX = 8'd1;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [fisd_pkg::MAX_WIDTH-1:0] cfg_wr_data;

    fisd_in_if  in_if ();
    fisd_out_if out_if ();

    flux_interval_stream_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_stream   (in_if),
        .out_stream  (out_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Decoder state as predicted from the accepted bytes
    fisd_pkg::phase_t                  dec_phase;
    logic [fisd_pkg::PREFIX_WIDTH-1:0] dec_prefix;
    logic [fisd_pkg::TICK_WIDTH-1:0]   dec_acc;
    int unsigned                       dec_count;
    bit                                dec_done;
    logic [fisd_pkg::MAX_WIDTH-1:0]    dec_limit;

    fisd_pkg::result_t results_due[$];
    int                fail_count;
    int                bytes_sent;
    int                burst_left;
    int                hold_request;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic bit limit_reached();
        return dec_count >= dec_limit || dec_count >= COUNT_CAP;
    endfunction

    task automatic close_stream();
        fisd_pkg::result_t r;
        r.interval_ticks = '0;
        r.stream_end     = 1'b1;
        r.interval_count = fisd_pkg::OUT_COUNT_WIDTH'(dec_count);
        results_due.push_back(r);
        dec_done  = 1'b1;
        dec_phase = fisd_pkg::PH_IDLE;
    endtask

    task automatic append_interval(input logic [fisd_pkg::TICK_WIDTH-1:0] ticks);
        fisd_pkg::result_t r;
        dec_count++;
        r.interval_ticks = ticks;
        r.stream_end     = 1'b0;
        r.interval_count = fisd_pkg::OUT_COUNT_WIDTH'(dec_count);
        results_due.push_back(r);
        dec_phase = fisd_pkg::PH_IDLE;
        if (limit_reached())
            close_stream();
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic lst);
        if (!dec_done)
        begin
            case (dec_phase)
                fisd_pkg::PH_IDLE:
                begin
                    if (limit_reached() || b == fisd_pkg::BYTE_STREAM_END)
                        close_stream();
                    else if (b <= fisd_pkg::BYTE_DIRECT_MAX)
                        append_interval(fisd_pkg::TICK_WIDTH'(b));
                    else if (b <= fisd_pkg::BYTE_PAIR_MAX)
                    begin
                        dec_prefix = fisd_pkg::PREFIX_WIDTH'(b - fisd_pkg::BYTE_PAIR_MIN);
                        dec_phase  = fisd_pkg::PH_PAIR;
                    end
                    else
                        dec_phase = fisd_pkg::PH_OPCODE;
                end
                fisd_pkg::PH_PAIR:
                    append_interval(fisd_pkg::PAIR_BASE
                                    + fisd_pkg::TICK_WIDTH'(dec_prefix) * 27'd255
                                    + fisd_pkg::TICK_WIDTH'(b));
                fisd_pkg::PH_OPCODE:
                begin
                    if (b == fisd_pkg::OPCODE_SPACE)
                    begin
                        dec_acc   = '0;
                        dec_phase = fisd_pkg::PH_SPACE0;
                    end
                    else
                        dec_phase = fisd_pkg::PH_IDLE;
                end
                fisd_pkg::PH_SPACE0:
                begin
                    dec_acc   = fisd_pkg::TICK_WIDTH'(b[6:1]);
                    dec_phase = fisd_pkg::PH_SPACE1;
                end
                fisd_pkg::PH_SPACE1:
                begin
                    dec_acc[12:6] = b[7:1];
                    dec_phase     = fisd_pkg::PH_SPACE2;
                end
                fisd_pkg::PH_SPACE2:
                begin
                    dec_acc[19:13] = b[7:1];
                    dec_phase      = fisd_pkg::PH_SPACE3;
                end
                fisd_pkg::PH_SPACE3:
                begin
                    dec_acc[26:20] = b[7:1];
                    append_interval(dec_acc);
                end
                default:
                    dec_phase = fisd_pkg::PH_IDLE;
            endcase
        end
        if (lst)
        begin
            if (!dec_done)
                close_stream();
            dec_phase  = fisd_pkg::PH_IDLE;
            dec_prefix = '0;
            dec_acc    = '0;
            dec_count  = 0;
            dec_done   = 1'b0;
        end
    endtask

    // Offer one byte; bursts of random length separated by random gaps
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0)
            begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        in_if.last_byte <= lst;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        decode_byte(b, lst);
        bytes_sent++;
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic drain();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(input logic [fisd_pkg::MAX_WIDTH-1:0] value);
        drain();
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        dec_limit = value;
    endtask

    // Well-formed sequences with random content, some noise, and a random ending
    task automatic send_random_stream(input int n_seq);
        logic [7:0] seq[$];
        int         kind;
        for (int i = 0; i < n_seq; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
                seq.push_back(8'($urandom_range(1, 249)));
            else if (kind < 60)
            begin
                seq.push_back(8'($urandom_range(250, 254)));
                seq.push_back(8'($urandom_range(0, 255)));
            end
            else if (kind < 80)
            begin
                seq.push_back(BYTE_OPCODE);
                seq.push_back(fisd_pkg::OPCODE_SPACE);
                repeat (4) seq.push_back(8'($urandom_range(0, 255)));
            end
            else if (kind < 88)
            begin
                seq.push_back(BYTE_OPCODE);
                seq.push_back(8'($urandom_range(0, 255)));
            end
            else
                seq.push_back(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 3))
            0:
            begin
                seq.push_back(fisd_pkg::BYTE_STREAM_END);
                repeat ($urandom_range(0, 4)) seq.push_back(8'($urandom_range(0, 255)));
            end
            1:
            begin
                seq.push_back(BYTE_OPCODE);
                if ($urandom_range(0, 1))
                begin
                    seq.push_back(fisd_pkg::OPCODE_SPACE);
                    repeat ($urandom_range(0, 3)) seq.push_back(8'($urandom_range(0, 255)));
                end
            end
            2:
                seq.push_back(8'($urandom_range(250, 254)));
            default:
                if (seq.size() == 0)
                    seq.push_back(8'($urandom_range(1, 249)));
        endcase
        foreach (seq[i])
            send_byte(seq[i], i == seq.size() - 1);
    endtask

    task automatic test_direct_codes();
        set_limit(fisd_pkg::MAX_INTERVALS_RESET);
        send_byte(8'd1, 1'b0);
        send_byte(fisd_pkg::BYTE_DIRECT_MAX, 1'b0);
        send_byte(8'd128, 1'b0);
    endtask

    task automatic test_pair_codes();
        send_byte(fisd_pkg::BYTE_PAIR_MIN, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(fisd_pkg::BYTE_PAIR_MAX, 1'b0);
        send_byte(8'd255, 1'b0);
        // zero second byte
        send_byte(8'd252, 1'b0);
        send_byte(8'd0, 1'b0);
    endtask

    task automatic test_space_codes();
        send_byte(BYTE_OPCODE, 1'b0);
        send_byte(fisd_pkg::OPCODE_SPACE, 1'b0);
        repeat (4) send_byte(8'hFF, 1'b0);
        send_byte(BYTE_OPCODE, 1'b0);
        send_byte(fisd_pkg::OPCODE_SPACE, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        // opcode zero and index are skipped
        send_byte(BYTE_OPCODE, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(BYTE_OPCODE, 1'b0);
        send_byte(OPCODE_INDEX, 1'b0);
    endtask

    task automatic test_stream_end();
        send_byte(fisd_pkg::BYTE_STREAM_END, 1'b0);
        send_byte(8'd33, 1'b0);
        send_byte(fisd_pkg::BYTE_PAIR_MIN, 1'b1);
        // last flag cuts a pair short
        send_byte(8'd253, 1'b1);
        send_byte(fisd_pkg::BYTE_STREAM_END, 1'b1);
        send_byte(8'd5, 1'b1);
    endtask

    task automatic test_limit_sweep();
        logic [fisd_pkg::MAX_WIDTH-1:0] limits[$];
        limits = {20'd0, 20'd1, 20'd2, 20'd5, fisd_pkg::MAX_INTERVALS_RESET - 20'd1,
                  fisd_pkg::MAX_WIDTH'($urandom_range(3, 12)),
                  fisd_pkg::MAX_INTERVALS_RESET};
        foreach (limits[i])
        begin
            set_limit(limits[i]);
            repeat (3) send_random_stream($urandom_range(1, 10));
        end
    endtask

    task automatic test_backpressure();
        hold_request = LONG_HOLD;
        for (int i = 0; i < 40; i++)
            send_byte(8'($urandom_range(1, 249)), i == 39);
    endtask

    task automatic test_random_streams();
        while (bytes_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
                set_limit($urandom_range(0, 1) ? fisd_pkg::MAX_WIDTH'($urandom_range(0, 30))
                                               : fisd_pkg::MAX_INTERVALS_RESET);
            send_random_stream($urandom_range(0, 12));
        end
    endtask

    // Receiver: stall patterns that change over time, plus the long hold on request
    initial
    begin
        int                hold_left;
        int                mode_left;
        int                stall_mode;
        int                cyc;
        fisd_pkg::result_t got;
        fisd_pkg::result_t want;
        hold_left  = 0;
        mode_left  = 0;
        stall_mode = 0;
        cyc        = 0;
        out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (rst_n && out_if.valid && out_if.ready)
            begin
                got.interval_ticks = out_if.interval_ticks;
                got.stream_end     = out_if.stream_end;
                got.interval_count = out_if.interval_count;
                if (results_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: ticks %0d end %0b count %0d",
                                 got.interval_ticks, got.stream_end, got.interval_count);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got.interval_ticks !== want.interval_ticks
                        || got.stream_end !== want.stream_end
                        || got.interval_count !== want.interval_count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected ticks %0d end %0b count %0d,",
                                     want.interval_ticks, want.stream_end,
                                     want.interval_count,
                                     " got ticks %0d end %0b count %0d",
                                     got.interval_ticks, got.stream_end,
                                     got.interval_count);
                    end
                end
            end
            if (hold_left == 0 && hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_if.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 200);
                end
                mode_left--;
                case (stall_mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 3) != 0);
                    2: out_if.ready <= (cyc % 4 != 0);
                    default: out_if.ready <= ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing is accepted for too long
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n)
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        fail_count   = 0;
        bytes_sent   = 0;
        burst_left   = 0;
        hold_request = 0;
        dec_phase    = fisd_pkg::PH_IDLE;
        dec_prefix   = '0;
        dec_acc      = '0;
        dec_count    = 0;
        dec_done     = 1'b0;
        dec_limit    = fisd_pkg::MAX_INTERVALS_RESET;
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        in_if.valid     <= 1'b0;
        in_if.data_byte <= '0;
        in_if.last_byte <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_direct_codes();
        test_pair_codes();
        test_space_codes();
        test_stream_end();
        test_limit_sweep();
        set_limit(fisd_pkg::MAX_INTERVALS_RESET);
        test_backpressure();
        test_random_streams();

        drain();
        repeat (20) @(posedge clk);
        if (results_due.size() == 0 && fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
